/* hdl/sfcd_pkg.sv */
// Shared types, constants and the byte-wide CRC update for the sensor frame decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sfcd_pkg;

	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 16;
	localparam int POS_W    = 3;

	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	// Byte positions within a response frame
	localparam logic [POS_W-1:0] POS_HDR_ADDR = 3'd0;
	localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd2;
	localparam logic [POS_W-1:0] POS_HUM_LO   = 3'd3;
	localparam logic [POS_W-1:0] POS_TMP_HI   = 3'd4;
	localparam logic [POS_W-1:0] POS_TMP_LO   = 3'd5;
	localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
	localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              frame_start;
	} in_word_t;

	typedef struct packed {
		logic        [WORD_W-1:0] humidity_tenths;
		logic signed [WORD_W-1:0] temperature_tenths;
		logic                     status;
	} res_word_t;

	// Core to output stage: one decoded frame and its strobe
	typedef struct packed {
		logic      load;
		res_word_t data;
	} res_load_t;

	// Reflected CRC-16, one byte, eight bit steps on a 16-bit value
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
	                                               input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/sfcd_in_if.sv */
// Byte channel into the decoder: valid/ready handshake plus one received byte.
// Depends on sfcd_pkg for widths.
`default_nettype none

interface sfcd_in_if
	import sfcd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

/* hdl/sfcd_out_if.sv */
// Result channel out of the decoder: valid/ready handshake plus one decoded frame.
// Depends on sfcd_pkg for widths.
`default_nettype none

interface sfcd_out_if
	import sfcd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic        [WORD_W-1:0] humidity_tenths;
	logic signed [WORD_W-1:0] temperature_tenths;
	logic                     status;

	modport source (output valid, output humidity_tenths, output temperature_tenths,
	                output status, input ready);
	modport sink   (input valid, input humidity_tenths, input temperature_tenths,
	                input status, output ready);
endinterface

`default_nettype wire

/* hdl/sfcd_in_stage.sv */
// Input register of the decoder: holds one accepted byte until the core takes it.
// Depends on sfcd_pkg and sfcd_in_if.
`default_nettype none

module sfcd_in_stage
	import sfcd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfcd_in_if.sink    rx,
	input  wire logic  take,
	output logic       valid_s1,
	output in_word_t   word_s1
);

	logic valid_q;

	assign rx.ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rx.ready) begin
			valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			word_s1 <= '{rx_byte: rx.rx_byte, frame_start: rx.frame_start};
		end
	end

endmodule

`default_nettype wire

/* hdl/sfcd_frame_core.sv */
// Frame position, running CRC and field capture; builds the decoded frame on the last byte.
// Depends on sfcd_pkg.
`default_nettype none

module sfcd_frame_core
	import sfcd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid_s1,
	input  wire in_word_t word_s1,
	input  wire logic     out_free,
	output logic          take,
	output res_load_t     res_load
);

	logic [POS_W-1:0]  byte_index_q;
	logic [WORD_W-1:0] crc_q;
	logic [WORD_W-1:0] humidity_q;
	logic [WORD_W-1:0] temperature_q;
	logic [BYTE_W-1:0] crc_low_q;

	logic [POS_W-1:0]  pos;
	logic [WORD_W-1:0] crc_base;
	logic [WORD_W-2:0] mag;
	logic              last;

	// A frame start restarts the frame on this very byte
	assign pos      = word_s1.frame_start ? POS_HDR_ADDR : byte_index_q;
	assign crc_base = word_s1.frame_start ? CRC_INIT : crc_q;
	assign last     = (pos == POS_CRC_HI);
	assign take     = valid_s1 && (!last || out_free);

	assign mag = temperature_q[WORD_W-2:0];

	always_comb begin
		res_load.load                    = take && last;
		res_load.data.humidity_tenths    = humidity_q;
		// Sign-magnitude to two's complement; negative zero comes out as zero
		if (temperature_q[WORD_W-1] && (mag != '0)) begin
			res_load.data.temperature_tenths = -$signed({1'b0, mag});
		end else begin
			res_load.data.temperature_tenths = $signed({1'b0, mag});
		end
		res_load.data.status = (crc_q != {word_s1.rx_byte, crc_low_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			crc_q         <= CRC_INIT;
			humidity_q    <= '0;
			temperature_q <= '0;
			crc_low_q     <= '0;
		end else if (take) begin
			if (last) begin
				byte_index_q <= '0;
				crc_q        <= CRC_INIT;
			end else begin
				byte_index_q <= pos + 1'b1;
				if (pos <= POS_TMP_LO) begin
					crc_q <= crc_byte(crc_base, word_s1.rx_byte);
				end else begin
					crc_q <= crc_base;
				end
			end
			case (pos)
				POS_HUM_HI: humidity_q[WORD_W-1:BYTE_W]    <= word_s1.rx_byte;
				POS_HUM_LO: humidity_q[BYTE_W-1:0]         <= word_s1.rx_byte;
				POS_TMP_HI: temperature_q[WORD_W-1:BYTE_W] <= word_s1.rx_byte;
				POS_TMP_LO: temperature_q[BYTE_W-1:0]      <= word_s1.rx_byte;
				POS_CRC_LO: crc_low_q                      <= word_s1.rx_byte;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/sfcd_out_stage.sv */
// Output register of the decoder: holds one decoded frame until the receiver takes it.
// Depends on sfcd_pkg and sfcd_out_if.
`default_nettype none

module sfcd_out_stage
	import sfcd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_load_t res_load,
	output logic           out_free,
	sfcd_out_if.source     res
);

	logic      valid_q;
	res_word_t data_q;

	assign out_free               = !valid_q || res.ready;
	assign res.valid              = valid_q;
	assign res.humidity_tenths    = data_q.humidity_tenths;
	assign res.temperature_tenths = data_q.temperature_tenths;
	assign res.status             = data_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_load.load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load.load) begin
			data_q <= res_load.data;
		end
	end

endmodule

`default_nettype wire

/* hdl/sensor_frame_crc_decoder.sv */
// Sensor response frame decoder: CRC-16 check and field extraction, one byte per word.
// Depends on sfcd_pkg, sfcd_in_if, sfcd_out_if, sfcd_in_stage, sfcd_frame_core, sfcd_out_stage.
//
// Usage:
//   rx  : one received frame byte per word, with frame_start high on byte 0 of a frame.
//         Eight bytes make a frame: header (2), humidity (2, big-endian), temperature
//         (2, sign-magnitude), CRC low, CRC high. The CRC covers bytes 0 to 5.
//   res : one word per completed frame: humidity in tenths, temperature in tenths
//         (two's complement), status 0 when the CRC matched and 1 when it did not.
//         A bad CRC still delivers the captured fields.
//   Throughput is one byte per clock while the receiver keeps up: the byte-wide CRC update sits
//   between the input register and the frame state and is combinational.
//   From acceptance of byte 7, the decoded word passes the input register, then the output
//   register, to res.valid.
//   A frame_start mid-frame drops the partial frame; after byte 7 the position wraps and
//   the next byte begins a new frame even without frame_start.
//   Reset clears both registers' valid flags, the byte position and the CRC.
//   When the receiver stalls, the decoded word waits in the output register while bytes
//   of the next frame keep flowing; only the last byte of that next frame waits in the
//   input register, and rx.ready drops only then.
`default_nettype none

module sensor_frame_crc_decoder
	import sfcd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfcd_in_if.sink    rx,
	sfcd_out_if.source res
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      take;
	logic      out_free;
	res_load_t res_load;

	// Hold the accepted byte for the core
	sfcd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	// Advance frame position, CRC and captured fields
	sfcd_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.out_free (out_free),
		.take     (take),
		.res_load (res_load)
	);

	// Hold the decoded frame until the receiver takes it
	sfcd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.out_free (out_free),
		.res      (res)
	);

endmodule

`default_nettype wire

/* hdl/sfcd_checker.sv */
// Port-level checks on the sensor frame decoder, bound to its top level.
// Depends on sfcd_pkg and sensor_frame_crc_decoder.
`default_nettype none

module sfcd_checker
	import sfcd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rx_valid,
	input wire logic              rx_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [WORD_W-1:0] res_humidity,
	input wire logic [WORD_W-1:0] res_temperature,
	input wire logic              res_status
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(res_humidity) && $stable(res_temperature) && $stable(res_status))
		else $error("result changed while stalled");

	// Input stays open whenever the output register is empty
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input blocked with empty output register");

	// A fresh result follows the last byte through the input register, then the output register
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result without a byte two cycles earlier");

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_valid        (rx.valid),
	.rx_ready        (rx.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_humidity    (res.humidity_tenths),
	.res_temperature (res.temperature_tenths),
	.res_status      (res.status)
);

`default_nettype wire

/* tb/tb_sensor_frame_crc_decoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sensor_frame_crc_decoder: feeds response frames byte by byte.
// Depends on sfcd_pkg, sfcd_in_if, sfcd_out_if and the decoder RTL.

module tb_sensor_frame_crc_decoder;
	import sfcd_pkg::*;

	localparam int ITEM_GOAL    = 1800;   // bytes to offer before the run winds down
	localparam int CALM_SPAN    = 250;    // last bytes sent with no idling on either side
	localparam int LONG_HOLD    = 120;    // cycles the receiver holds off in one stretch
	localparam int DRAIN_LIMIT  = 20000;  // cycles to wait for outstanding frames at the end
	localparam int TAIL_CYCLES  = 8;      // cycles to let the pipeline settle after the drain
	localparam int RUN_LIMIT_NS = 400000;

	// Scoreboard: tracks the frame decoder state and holds the decoded frames still owed
	class frame_scoreboard;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] crc;
		logic [WORD_W-1:0] hum;
		logic [WORD_W-1:0] tmp;
		logic [BYTE_W-1:0] crc_lo;
		res_word_t         frames_due[$];
		int                errors;

		function new();
			pos    = POS_HDR_ADDR;
			crc    = CRC_INIT;
			hum    = '0;
			tmp    = '0;
			crc_lo = '0;
			errors = 0;
		endfunction

		// Reflected CRC-16, one data bit at a time, LSB first
		static function logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] c_in,
		                                             input logic [BYTE_W-1:0] b);
			logic [WORD_W-1:0] c;
			logic              fb;
			c = c_in;
			for (int i = 0; i < BYTE_W; i++) begin
				fb = c[0] ^ b[i];
				c  = c >> 1;
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		// Advance the decoder state by one accepted byte; queue a frame after byte 7
		function void decode_byte(input in_word_t w);
			logic [WORD_W-1:0] mag;
			logic [WORD_W-1:0] rcv;
			res_word_t         r;
			if (w.frame_start) begin
				pos = POS_HDR_ADDR;
				crc = CRC_INIT;
			end
			if (pos <= POS_TMP_LO) begin
				crc = crc_step(crc, w.rx_byte);
			end
			case (pos)
				POS_HUM_HI: begin
					hum[15:8] = w.rx_byte;
				end
				POS_HUM_LO: begin
					hum[7:0] = w.rx_byte;
				end
				POS_TMP_HI: begin
					tmp[15:8] = w.rx_byte;
				end
				POS_TMP_LO: begin
					tmp[7:0] = w.rx_byte;
				end
				POS_CRC_LO: begin
					crc_lo = w.rx_byte;
				end
				default: begin
				end
			endcase
			if (pos == POS_CRC_HI) begin
				rcv = {w.rx_byte, crc_lo};
				mag = {1'b0, tmp[14:0]};
				r.humidity_tenths    = hum;
				// sign-magnitude to two's complement; a negative zero stays zero
				r.temperature_tenths = (tmp[15] && mag != '0) ? -mag : mag;
				r.status             = (crc != rcv);
				frames_due.push_back(r);
				pos = POS_HDR_ADDR;
				crc = CRC_INIT;
			end else begin
				pos = pos + 1'b1;
			end
		endfunction

		function void report(input string what, input int want, input int got);
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_word(input res_word_t got);
			res_word_t want;
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: decoded word with none expected: hum %0d temp %0d status %0d",
				         $time, got.humidity_tenths, got.temperature_tenths, got.status);
				return;
			end
			want = frames_due.pop_front();
			if (got.humidity_tenths !== want.humidity_tenths) begin
				report("humidity_tenths", int'(want.humidity_tenths),
				       int'(got.humidity_tenths));
			end
			if (got.temperature_tenths !== want.temperature_tenths) begin
				report("temperature_tenths", int'(want.temperature_tenths),
				       int'(got.temperature_tenths));
			end
			if (got.status !== want.status) begin
				report("status", int'(want.status), int'(got.status));
			end
		endfunction

		function int due();
			return frames_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sfcd_in_if  rx_if ();
	sfcd_out_if res_if ();

	sensor_frame_crc_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	frame_scoreboard sb;
	int              bytes_sent = 0;
	int              idle_pct   = 0;   // sender gap chance per byte, changed per frame
	bit              calm       = 1'b0; // set for the final stretch: no idling anywhere

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one byte and hold it until the decoder takes it. Leave valid high on return
	// so back-to-back words need no bubble; a gap, when drawn, lowers valid first.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
		in_word_t w;
		if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		rx_if.valid       <= 1'b1;
		rx_if.rx_byte     <= b;
		rx_if.frame_start <= s;
		@(posedge clk);
		while (!rx_if.ready) begin
			@(posedge clk);
		end
		w.rx_byte     = b;
		w.frame_start = s;
		sb.decode_byte(w);
		bytes_sent++;
	endtask

	// Build a response frame with its CRC, optionally corrupted by xor with flip, and
	// send its first cut bytes. lead is the frame_start flag of byte 0.
	task automatic send_frame(input logic [WORD_W-1:0] hum, input logic [WORD_W-1:0] tmp,
	                          input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
	                          input logic [WORD_W-1:0] flip, input logic lead, input int cut);
		logic [BYTE_W-1:0] fb[8];
		logic [WORD_W-1:0] c;
		fb[0] = h0;
		fb[1] = h1;
		fb[2] = hum[15:8];
		fb[3] = hum[7:0];
		fb[4] = tmp[15:8];
		fb[5] = tmp[7:0];
		c = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			c = frame_scoreboard::crc_step(c, fb[i]);
		end
		c     = c ^ flip;
		fb[6] = c[7:0];
		fb[7] = c[15:8];
		for (int i = 0; i < cut; i++) begin
			send_byte(fb[i], (i == 0) ? lead : 1'b0);
		end
	endtask

	// Receiver: check each accepted word, stall in short random bursts, and twice hold off
	// for a long stretch so the decoder fills up and drops rx.ready.
	initial begin : res_side
		int        stall_left;
		int        stall_pct;
		int        words_taken;
		int        cyc;
		res_word_t got;
		stall_left  = 0;
		stall_pct   = 0;
		words_taken = 0;
		cyc         = 0;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.humidity_tenths    = res_if.humidity_tenths;
				got.temperature_tenths = res_if.temperature_tenths;
				got.status             = res_if.status;
				sb.check_word(got);
				words_taken++;
				if ((words_taken == 30 || words_taken == 100) && !calm) begin
					stall_left = LONG_HOLD;
				end
			end
			// the stall mix is redrawn as cyc advances; some stretches run with no stalls
			cyc++;
			if (cyc % 32 == 0) begin
				case ($urandom_range(0, 3))
					0, 1: stall_pct = 0;
					2:    stall_pct = 20;
					default: stall_pct = 50;
				endcase
			end
			if (stall_left == 0 && !calm && stall_pct != 0 &&
			    $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 5);
			end
			res_if.ready <= (stall_left == 0);
			if (stall_left > 0) begin
				stall_left--;
			end
		end
	end

	// Stimulus and end of run
	initial begin : rx_side
		int                pick;
		int                drain;
		int                n;
		logic [WORD_W-1:0] hum;
		logic [WORD_W-1:0] tmp;
		logic [WORD_W-1:0] flip;
		sb = new();
		arst_n            = 1'b0;
		rx_if.valid       = 1'b0;
		rx_if.rx_byte     = '0;
		rx_if.frame_start = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: negative zero with full-scale humidity and extreme header bytes
		send_frame(16'hFFFF, 16'h8000, 8'h00, 8'hFF, 16'h0000, 1'b1, 8);
		// next frame with no frame_start after a full one; most negative temperature,
		// zero humidity and a corrupted CRC
		send_frame(16'h0000, 16'hFFFF, 8'hFF, 8'h00, 16'h0001, 1'b0, 8);
		// drop a partial frame by restarting, then the largest positive temperature
		send_frame(16'h1234, 16'h0001, 8'h03, 8'h04, 16'h0000, 1'b1, 3);
		send_frame(16'h01F4, 16'h7FFF, 8'h03, 8'h04, 16'h0000, 1'b1, 8);

		// Random: mostly well-formed frames with random content, some broken or noisy
		while (bytes_sent < ITEM_GOAL) begin
			calm = (bytes_sent >= ITEM_GOAL - CALM_SPAN);
			if (calm) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0, 1: idle_pct = 0;
					2:    idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			hum = 16'($urandom_range(0, 65535));
			case ($urandom_range(0, 7))
				0:       tmp = 16'h8000;
				1:       tmp = 16'h8000 | 16'($urandom_range(0, 400));
				2:       tmp = 16'($urandom_range(0, 400));
				default: tmp = 16'($urandom_range(0, 65535));
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(hum, tmp, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           16'h0000, 1'b1, 8);
			end else if (pick < 78) begin
				// corrupt the check value: one flipped bit or an arbitrary pattern
				flip = $urandom_range(0, 1) ? (16'h0001 << $urandom_range(0, 15))
				                            : 16'($urandom_range(1, 65535));
				send_frame(hum, tmp, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           flip, 1'b1, 8);
			end else if (pick < 86) begin
				send_frame(hum, tmp, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           16'h0000, 1'b0, 8);
			end else if (pick < 94) begin
				send_frame(hum, tmp, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           16'h0000, 1'b1, $urandom_range(1, 7));
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
				end
			end
		end
		rx_if.valid <= 1'b0;

		// Drain: wait for every owed frame, then let the pipeline settle
		drain = 0;
		while (sb.due() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.due() == 0 && sb.errors == 0) begin
			$display("[sensor_frame_crc_decoder] OK");
		end else begin
			$display("[sensor_frame_crc_decoder] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("[sensor_frame_crc_decoder] ERROR");
		$finish;
	end

endmodule
